// ----- design/terminal_line_editor_macros.svh -----
// assertion macros used by the terminal line editor checker
// no dependencies; include by bare file name
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("terminal_line_editor: assertion failed");

// next-cycle implication, disabled while in reset
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("terminal_line_editor: assertion failed");

`endif

// ----- design/tle_pkg.sv -----
// shared types and constants of the terminal line editor
// used by tle_ctrl, tle_dpath, terminal_line_editor and tle_checker
package tle_pkg;

	localparam logic [7:0] CH_ESC = 8'd27;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_UPA = 8'h41;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LF,
		S_SP,
		S_BS2,
		S_RD,
		S_CHK,
		S_END,
		S_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_SEEN,
		ESC_BRKT
	} esc_t;

	typedef enum logic [2:0] {
		SEL_CH,
		SEL_CR,
		SEL_LF,
		SEL_BS,
		SEL_SP,
		SEL_RD,
		SEL_ZERO
	} sel_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_INC,
		CUR_DEC,
		CUR_CLR,
		CUR_IDX
	} cur_op_t;

	typedef struct packed {
		logic       capture;
		logic       push;
		logic [1:0] kind;
		sel_t       sel;
		logic       flush;
		logic       wr;
		logic       wr_zero;
		cur_op_t    cur_op;
		logic       idx_clr;
		logic       idx_inc;
		logic       rd;
	} cmd_t;

	typedef struct packed {
		logic is_esc;
		logic is_lbr;
		logic is_upa;
		logic is_cr;
		logic is_bs;
		logic cur_zero;
		logic cur_room;
		logic rd_nz;
		logic idx_lt_cur;
		logic idx_lt_max;
		logic push_ok;
	} sts_t;

endpackage

// ----- design/tle_dpath.sv -----
// datapath of the terminal line editor: line store, cursor, walk index, output staging
// depends on tle_pkg; driven by tle_ctrl
module tle_dpath #(
	parameter int LINE_LEN = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tle_pkg::cmd_t  cmd,
	output tle_pkg::sts_t  sts,
	input  logic [7:0]     s_tdata,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [7:0]     m_tdata,   // out_byte
	output logic [1:0]     m_tuser,   // out_kind
	output logic           m_tlast
);

	localparam int CW = $clog2(LINE_LEN);
	localparam logic [CW-1:0] LAST_SLOT = CW'(LINE_LEN - 1);

	logic [7:0]    ch_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    mem [LINE_LEN];
	logic [LINE_LEN-1:0] vld_q;
	logic [7:0]    rd_data_q;
	logic          rd_vld_q;
	logic [7:0]    rd_byte;
	logic          hold_v_q;
	logic [7:0]    hold_byte_q;
	logic [1:0]    hold_kind_q;
	logic          m_valid_q;
	logic [7:0]    m_byte_q;
	logic [1:0]    m_kind_q;
	logic          m_last_q;
	logic [7:0]    push_byte;
	logic          out_free;

	assign rd_byte  = rd_vld_q ? rd_data_q : 8'h00;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		unique case (cmd.sel)
			tle_pkg::SEL_CH:   push_byte = ch_q;
			tle_pkg::SEL_CR:   push_byte = tle_pkg::CH_CR;
			tle_pkg::SEL_LF:   push_byte = tle_pkg::CH_LF;
			tle_pkg::SEL_BS:   push_byte = tle_pkg::CH_BS;
			tle_pkg::SEL_SP:   push_byte = tle_pkg::CH_SP;
			tle_pkg::SEL_RD:   push_byte = rd_byte;
			default:           push_byte = 8'h00;
		endcase
	end

	always_comb begin
		sts.is_esc     = (ch_q == tle_pkg::CH_ESC);
		sts.is_lbr     = (ch_q == tle_pkg::CH_LBR);
		sts.is_upa     = (ch_q == tle_pkg::CH_UPA);
		sts.is_cr      = (ch_q == tle_pkg::CH_CR);
		sts.is_bs      = (ch_q == tle_pkg::CH_BS);
		sts.cur_zero   = (cursor_q == '0);
		sts.cur_room   = (cursor_q != LAST_SLOT);
		sts.rd_nz      = (rd_byte != 8'h00);
		sts.idx_lt_cur = (idx_q < cursor_q);
		sts.idx_lt_max = (idx_q != LAST_SLOT);
		sts.push_ok    = !hold_v_q || out_free;
	end

	// received byte
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q <= s_tdata;
		end
	end

	// cursor and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			idx_q    <= '0;
		end else begin
			case (cmd.cur_op)
				tle_pkg::CUR_INC: cursor_q <= cursor_q + CW'(1);
				tle_pkg::CUR_DEC: cursor_q <= cursor_q - CW'(1);
				tle_pkg::CUR_CLR: cursor_q <= '0;
				tle_pkg::CUR_IDX: cursor_q <= idx_q;
				default:          cursor_q <= cursor_q;
			endcase
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// line store, one write port at cursor, one registered read port at idx
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cursor_q] <= cmd.wr_zero ? 8'h00 : ch_q;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				vld_q[cursor_q] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_vld_q <= vld_q[idx_q];
			end
		end
	end

	// hold stage keeps one beat back so the final one can carry tlast
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if ((cmd.push || cmd.flush) && hold_v_q) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cmd.push) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.push || cmd.flush) && hold_v_q) begin
			m_byte_q <= hold_byte_q;
			m_kind_q <= hold_kind_q;
			m_last_q <= cmd.flush;
		end
		if (cmd.push) begin
			hold_byte_q <= push_byte;
			hold_kind_q <= cmd.kind;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

// ----- design/tle_ctrl.sv -----
// controller of the terminal line editor: escape tracking and per-byte sequencing
// depends on tle_pkg; commands tle_dpath
module tle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  tle_pkg::sts_t  sts,
	output tle_pkg::cmd_t  cmd
);

	tle_pkg::state_t state_q, state_d;
	tle_pkg::esc_t   esc_q, esc_d;
	logic            walk_cr_q, walk_cr_d;
	logic            normal;
	logic            up;
	logic            walk_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tle_pkg::S_IDLE;
			esc_q     <= tle_pkg::ESC_IDLE;
			walk_cr_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			esc_q     <= esc_d;
			walk_cr_q <= walk_cr_d;
		end
	end

	assign walk_more = sts.rd_nz && (walk_cr_q ? sts.idx_lt_cur : sts.idx_lt_max);

	always_comb begin
		state_d   = state_q;
		esc_d     = esc_q;
		walk_cr_d = walk_cr_q;
		cmd       = '0;
		s_tready  = 1'b0;
		normal    = 1'b1;
		up        = 1'b0;
		unique case (state_q)
			tle_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = tle_pkg::S_DECODE;
				end
			end
			tle_pkg::S_DECODE: begin
				unique case (esc_q)
					tle_pkg::ESC_IDLE: begin
						if (sts.is_esc) begin
							esc_d  = tle_pkg::ESC_SEEN;
							normal = 1'b0;
						end
					end
					tle_pkg::ESC_SEEN: begin
						if (sts.is_lbr) begin
							esc_d  = tle_pkg::ESC_BRKT;
							normal = 1'b0;
						end else begin
							esc_d = tle_pkg::ESC_IDLE;
						end
					end
					tle_pkg::ESC_BRKT: begin
						esc_d = tle_pkg::ESC_IDLE;
						if (sts.is_upa) begin
							up     = 1'b1;
							normal = 1'b0;
						end
					end
					default: begin
						esc_d = tle_pkg::ESC_IDLE;
					end
				endcase
				if (up) begin
					cmd.idx_clr = 1'b1;
					walk_cr_d   = 1'b0;
					state_d     = tle_pkg::S_RD;
				end else if (!normal) begin
					state_d = tle_pkg::S_IDLE;
				end else if (sts.is_cr) begin
					cmd.push  = 1'b1;
					cmd.kind  = tle_pkg::KIND_ECHO;
					cmd.sel   = tle_pkg::SEL_CR;
					walk_cr_d = 1'b1;
					state_d   = tle_pkg::S_LF;
				end else if (sts.is_bs) begin
					if (sts.cur_zero) begin
						state_d = tle_pkg::S_IDLE;
					end else begin
						cmd.cur_op = tle_pkg::CUR_DEC;
						cmd.push   = 1'b1;
						cmd.kind   = tle_pkg::KIND_ECHO;
						cmd.sel    = tle_pkg::SEL_BS;
						state_d    = tle_pkg::S_SP;
					end
				end else begin
					cmd.push = 1'b1;
					cmd.kind = tle_pkg::KIND_ECHO;
					cmd.sel  = tle_pkg::SEL_CH;
					if (sts.cur_room) begin
						cmd.wr     = 1'b1;
						cmd.cur_op = tle_pkg::CUR_INC;
					end
					state_d = tle_pkg::S_FLUSH;
				end
			end
			tle_pkg::S_LF: begin
				if (sts.push_ok) begin
					cmd.push    = 1'b1;
					cmd.kind    = tle_pkg::KIND_ECHO;
					cmd.sel     = tle_pkg::SEL_LF;
					cmd.wr      = 1'b1;
					cmd.wr_zero = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = tle_pkg::S_RD;
				end
			end
			tle_pkg::S_SP: begin
				if (sts.push_ok) begin
					cmd.push = 1'b1;
					cmd.kind = tle_pkg::KIND_ECHO;
					cmd.sel  = tle_pkg::SEL_SP;
					state_d  = tle_pkg::S_BS2;
				end
			end
			tle_pkg::S_BS2: begin
				if (sts.push_ok) begin
					cmd.push = 1'b1;
					cmd.kind = tle_pkg::KIND_ECHO;
					cmd.sel  = tle_pkg::SEL_BS;
					state_d  = tle_pkg::S_FLUSH;
				end
			end
			tle_pkg::S_RD: begin
				cmd.rd  = 1'b1;
				state_d = tle_pkg::S_CHK;
			end
			tle_pkg::S_CHK: begin
				if (walk_more) begin
					if (sts.push_ok) begin
						cmd.push    = 1'b1;
						cmd.kind    = walk_cr_q ? tle_pkg::KIND_LINE : tle_pkg::KIND_ECHO;
						cmd.sel     = tle_pkg::SEL_RD;
						cmd.idx_inc = 1'b1;
						state_d     = tle_pkg::S_RD;
					end
				end else if (walk_cr_q) begin
					state_d = tle_pkg::S_END;
				end else begin
					cmd.cur_op = tle_pkg::CUR_IDX;
					state_d    = tle_pkg::S_FLUSH;
				end
			end
			tle_pkg::S_END: begin
				if (sts.push_ok) begin
					cmd.push   = 1'b1;
					cmd.kind   = tle_pkg::KIND_END;
					cmd.sel    = tle_pkg::SEL_ZERO;
					cmd.cur_op = tle_pkg::CUR_CLR;
					state_d    = tle_pkg::S_FLUSH;
				end
			end
			tle_pkg::S_FLUSH: begin
				if (sts.push_ok) begin
					cmd.flush = 1'b1;
					state_d   = tle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tle_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/terminal_line_editor.sv -----
// Terminal line editor. Takes one received terminal byte per input beat and answers with a
// run of output beats (echo bytes, finished line bytes, end marker), tlast on the final beat
// of each run; a byte that gives no output (lone escape, escape bracket, backspace on an
// empty line) gives no beat. One byte is handled at a time. Replay (up arrow) and carriage return
// walk the line store through its single registered read port, reading and sending one stored
// byte after the other, and wait while the output side stalls. The line store reads as zero
// from reset on with no clearing pass.
// top level; depends on tle_pkg, tle_ctrl, tle_dpath
module terminal_line_editor #(
	parameter int LINE_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // out_kind
	output logic       m_tlast    // last
);

	tle_pkg::cmd_t cmd;
	tle_pkg::sts_t sts;

	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tle_dpath #(
		.LINE_LEN (LINE_LEN)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- design/tle_checker.sv -----
// port-level checks of the terminal line editor, bound to the top level
// depends on tle_pkg and terminal_line_editor_macros.svh
`include "terminal_line_editor_macros.svh"

module tle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// stalled beat holds
	`TLE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// only one byte in flight
	`TLE_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	`TLE_ASSERT_NOW(a_kind_legal, clk, arst_n, m_tvalid, m_tuser == tle_pkg::KIND_ECHO || m_tuser == tle_pkg::KIND_LINE || m_tuser == tle_pkg::KIND_END)

	// end marker is zero and closes the run
	`TLE_ASSERT_NOW(a_end_mark, clk, arst_n, m_tvalid && m_tuser == tle_pkg::KIND_END, m_tdata == 8'h00 && m_tlast)

	// line bytes stop before the terminator and never close the run
	`TLE_ASSERT_NOW(a_line_byte, clk, arst_n, m_tvalid && m_tuser == tle_pkg::KIND_LINE, m_tdata != 8'h00 && !m_tlast)

endmodule

bind terminal_line_editor tle_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- tb/sv/tb.sv -----
// self-checking bench for terminal_line_editor: directed keystroke table, then random lines
// and noise, each output beat compared against the table's beats or a line-editor model in the bench
// depends on tle_pkg and the terminal_line_editor design sources
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = 32;
	localparam int CLK_PERIOD = 10;
	localparam int PLAN_LEN = 25;
	localparam int RANDOM_PER_PHASE = 70;
	localparam int DRAIN_CYCLES = 2 * (2 * LINE_LEN + 6);
	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef beat_t [0:2] beat3_t;

	typedef struct {
		logic [7:0] rx;
		bit         typed;
		int         n;
		beat3_t     want;
	} row_t;

	localparam beat3_t SILENT = '0;
	localparam beat3_t RUBOUT = '{
		'{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0},
		'{tle_pkg::KIND_ECHO, tle_pkg::CH_SP, 1'b0},
		'{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	// model state of the edited line
	logic [7:0]    line_mem [LINE_LEN] = '{default: 8'h00};
	int            line_cur = 0;
	tle_pkg::esc_t line_esc = tle_pkg::ESC_IDLE;

	beat_t      run_beats [$];
	beat_t      tx_stream_q [$];
	beat_t      want;
	row_t       plan [PLAN_LEN];
	int         rx_sent = 0;
	int         errors = 0;
	int         quiet_cycles = 0;
	int         tx_gap_pct = 0;
	int         rx_stall_pct = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	terminal_line_editor #(
		.LINE_LEN(LINE_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	function automatic beat3_t lone_echo(input logic [7:0] ch);
		lone_echo = '0;
		lone_echo[0] = '{tle_pkg::KIND_ECHO, ch, 1'b1};
	endfunction

	// edits the model line with one received byte, leaves its output beats in run_beats
	function automatic void edit_line(input logic [7:0] ch);
		beat_t tail;
		int    i;
		bit    plain;
		run_beats.delete();
		plain = 1'b1;
		case (line_esc)
		tle_pkg::ESC_IDLE: begin
			if (ch == tle_pkg::CH_ESC) begin
				line_esc = tle_pkg::ESC_SEEN;
				plain = 1'b0;
			end
		end
		tle_pkg::ESC_SEEN: begin
			if (ch == tle_pkg::CH_LBR) begin
				line_esc = tle_pkg::ESC_BRKT;
				plain = 1'b0;
			end else begin
				line_esc = tle_pkg::ESC_IDLE;
			end
		end
		default: begin
			line_esc = tle_pkg::ESC_IDLE;
			if (ch == tle_pkg::CH_UPA) begin
				i = 0;
				while (i < LINE_LEN - 1 && line_mem[i] != 8'h00) begin
					run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, line_mem[i], 1'b0});
					i++;
				end
				line_cur = i;
				plain = 1'b0;
			end
		end
		endcase
		if (plain) begin
			if (ch == tle_pkg::CH_CR) begin
				run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, tle_pkg::CH_CR, 1'b0});
				run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, tle_pkg::CH_LF, 1'b0});
				line_mem[line_cur] = 8'h00;
				i = 0;
				while (i < line_cur && line_mem[i] != 8'h00) begin
					run_beats.push_back(beat_t'{tle_pkg::KIND_LINE, line_mem[i], 1'b0});
					i++;
				end
				run_beats.push_back(beat_t'{tle_pkg::KIND_END, 8'h00, 1'b0});
				line_cur = 0;
			end else if (ch == tle_pkg::CH_BS) begin
				if (line_cur > 0) begin
					line_cur--;
					run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0});
					run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, tle_pkg::CH_SP, 1'b0});
					run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0});
				end
			end else begin
				run_beats.push_back(beat_t'{tle_pkg::KIND_ECHO, ch, 1'b0});
				if (line_cur < LINE_LEN - 1) begin
					line_mem[line_cur] = ch;
					line_cur++;
				end
			end
		end
		if (run_beats.size() > 0) begin
			tail = run_beats.pop_back();
			tail.last = 1'b1;
			run_beats.push_back(tail);
		end
	endfunction

	// returns at the edge where the byte is taken
	task automatic push_byte(input logic [7:0] ch);
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		rx_sent++;
	endtask

	task automatic key(input logic [7:0] ch);
		push_byte(ch);
		edit_line(ch);
		foreach (run_beats[i]) tx_stream_q.push_back(run_beats[i]);
	endtask

	// mostly whole command lines, some of them overlong, the rest loose noise
	task automatic random_burst();
		int len;
		int k;
		if ($urandom_range(9) < 7) begin
			len = ($urandom_range(9) < 2) ? $urandom_range(40, 25) : $urandom_range(12, 0);
			for (k = 0; k < len; k++) begin
				case ($urandom_range(19))
				0, 1: key(tle_pkg::CH_BS);
				2: begin
					key(tle_pkg::CH_ESC);
					key(tle_pkg::CH_LBR);
					key(tle_pkg::CH_UPA);
				end
				default: key(8'($urandom_range(8'h7E, 8'h21)));
				endcase
			end
			key(tle_pkg::CH_CR);
		end else begin
			len = $urandom_range(6, 1);
			for (k = 0; k < len; k++) begin
				case ($urandom_range(7))
				0: key(tle_pkg::CH_ESC);
				1: key(tle_pkg::CH_LBR);
				2: key(tle_pkg::CH_UPA);
				3: key(tle_pkg::CH_CR);
				4: key(tle_pkg::CH_BS);
				default: key(8'($urandom_range(255, 0)));
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tx_stream_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual kind %0d byte %h last %b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = tx_stream_q.pop_front();
					if (m_tuser !== want.kind) begin
						errors++;
						$display("%0t: kind mismatch, expected %0d, actual %0d",
							$time, want.kind, m_tuser);
					end
					if (m_tdata !== want.data) begin
						errors++;
						$display("%0t: byte mismatch, expected %h, actual %h",
							$time, want.data, m_tdata);
					end
					if (m_tlast !== want.last) begin
						errors++;
						$display("%0t: last mismatch, expected %b, actual %b",
							$time, want.last, m_tlast);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int phase;
		int k;
		plan = '{
			'{tle_pkg::CH_BS,  1'b1, 0, SILENT},
			'{tle_pkg::CH_ESC, 1'b1, 0, SILENT},
			'{tle_pkg::CH_LBR, 1'b1, 0, SILENT},
			'{tle_pkg::CH_UPA, 1'b1, 0, SILENT},
			'{8'h00,           1'b1, 1, lone_echo(8'h00)},
			'{8'hFF,           1'b1, 1, lone_echo(8'hFF)},
			'{"h",             1'b1, 1, lone_echo("h")},
			'{tle_pkg::CH_BS,  1'b1, 3, RUBOUT},
			'{tle_pkg::CH_CR,  1'b0, 0, SILENT},
			'{"a",             1'b0, 0, SILENT},
			'{"b",             1'b0, 0, SILENT},
			'{tle_pkg::CH_ESC, 1'b1, 0, SILENT},
			'{"x",             1'b1, 1, lone_echo("x")},
			'{tle_pkg::CH_ESC, 1'b1, 0, SILENT},
			'{tle_pkg::CH_ESC, 1'b1, 1, lone_echo(tle_pkg::CH_ESC)},
			'{tle_pkg::CH_ESC, 1'b1, 0, SILENT},
			'{tle_pkg::CH_LBR, 1'b1, 0, SILENT},
			'{"B",             1'b1, 1, lone_echo("B")},
			'{tle_pkg::CH_ESC, 1'b1, 0, SILENT},
			'{tle_pkg::CH_LBR, 1'b1, 0, SILENT},
			'{tle_pkg::CH_UPA, 1'b0, 0, SILENT},
			'{tle_pkg::CH_CR,  1'b0, 0, SILENT},
			'{tle_pkg::CH_ESC, 1'b1, 0, SILENT},
			'{tle_pkg::CH_CR,  1'b0, 0, SILENT},
			'{tle_pkg::CH_BS,  1'b1, 0, SILENT}
		};
		tx_gap_pct = 37;
		rx_stall_pct = 70;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].typed) begin
				push_byte(plan[r].rx);
				edit_line(plan[r].rx);
				for (k = 0; k < plan[r].n; k++) tx_stream_q.push_back(plan[r].want[k]);
			end else begin
				key(plan[r].rx);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				tx_gap_pct = 37;
				rx_stall_pct = 70;
			end
			1: begin
				tx_gap_pct = 70;
				rx_stall_pct = 37;
			end
			default: begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end
			endcase
			while (rx_sent < PLAN_LEN + (phase + 1) * RANDOM_PER_PHASE) random_burst();
		end
		s_tvalid <= 1'b0;

		while (tx_stream_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/tle_pkg.sv
design/tle_dpath.sv
design/tle_ctrl.sv
design/terminal_line_editor.sv
design/tle_checker.sv
tb/sv/tb.sv
